FILE: hdl/ochp_pkg.sv
// Shared types and constants for the comment header parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ochp_pkg;

  // Parse phases of one packet
  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_VLEN   = 3'd1,
    PH_VBODY  = 3'd2,
    PH_COUNT  = 3'd3,
    PH_CLEN   = 3'd4,
    PH_CBODY  = 3'd5,
    PH_DONE   = 3'd6,
    PH_IGNORE = 3'd7
  } phase_t;

  // Result record kinds
  typedef enum logic [1:0] {
    KIND_VENDOR  = 2'd0,
    KIND_COMMENT = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  // Final packet status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRAILING  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // Byte position counter width and its saturation value
  localparam int POS_W = 33;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Shortest packet that can hold magic, vendor length and count
  localparam int MIN_PACKET = 8 + 4 + 4;

  // Depth of the event queue between parser and result stage
  localparam int QDEPTH = 4;

  // One parser event: an optional string record and an optional status
  typedef struct packed {
    logic        rec_valid;
    kind_t       rec_kind;
    logic [31:0] rec_index;
    logic [31:0] rec_offset;
    logic [31:0] rec_length;
    logic        stat_valid;
    status_t     status;
  } ev_t;

  // Expected magic word, one character per position
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h4F; // O
      3'd1: c = 8'h70; // p
      3'd2: c = 8'h75; // u
      3'd3: c = 8'h73; // s
      3'd4: c = 8'h54; // T
      3'd5: c = 8'h61; // a
      3'd6: c = 8'h67; // g
      3'd7: c = 8'h73; // s
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ochp_front.sv
// Parser front end: takes packet bytes and turns them into events.
// Depends on ochp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ochp_front #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          final_byte,
  output logic               ev_push,
  output ochp_pkg::ev_t      ev
);

  // Parser state
  ochp_pkg::phase_t              phase, phase_next;
  logic [ochp_pkg::POS_W-1:0]    pos;
  logic [1:0]                    field_byte_count;
  logic [31:0]                   length_accumulator;
  logic [LENGTH_BITS-1:0]        body_bytes_left;
  logic [LENGTH_BITS-1:0]        comments_left;
  logic [31:0]                   current_comment_index;
  logic                          bad_magic;

  // Per-byte decode
  logic                   active;
  logic                   magic_ok;
  logic                   pos_ge7;
  logic                   pos_short;
  logic                   gathering;
  logic                   done_word;
  logic [31:0]            acc_shifted;
  logic [31:0]            acc_full;
  logic [LENGTH_BITS-1:0] len_word;
  logic                   len_zero;
  logic                   body_last;
  logic                   last_comment;
  logic [31:0]            len_sel;
  logic [31:0]            start_here;
  logic                   bad_next;

  assign active     = accept && !bad_magic;
  assign magic_ok   = data_byte == ochp_pkg::magic_char(pos[2:0]);
  assign pos_ge7    = (|pos[ochp_pkg::POS_W-1:3]) || (pos[2:0] == 3'd7);
  assign pos_short  = pos < ochp_pkg::POS_W'(ochp_pkg::MIN_PACKET - 1);
  assign gathering  = active && (phase == ochp_pkg::PH_VLEN || phase == ochp_pkg::PH_COUNT ||
                                 phase == ochp_pkg::PH_CLEN);
  assign done_word  = gathering && (field_byte_count == 2'd3);

  // Little-endian length gathering; only the low LENGTH_BITS are kept
  assign acc_shifted = (field_byte_count == 2'd0) ? {24'd0, data_byte}
                     : length_accumulator | ({24'd0, data_byte} << {field_byte_count, 3'b000});
  assign acc_full    = {data_byte, length_accumulator[23:0]};
  assign len_word    = acc_full[LENGTH_BITS-1:0];
  assign len_zero    = len_word == '0;

  assign body_last    = body_bytes_left == LENGTH_BITS'(1);
  assign last_comment = comments_left == LENGTH_BITS'(1);

  // Start offset of a string that ends on this byte
  assign len_sel    = (phase == ochp_pkg::PH_VBODY || phase == ochp_pkg::PH_CBODY)
                    ? length_accumulator : 32'd0;
  assign start_here = pos[31:0] + 32'd1 - len_sel;

  assign bad_next = bad_magic || (active && phase == ochp_pkg::PH_MAGIC && !magic_ok);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (active) begin
      unique case (phase)
        ochp_pkg::PH_MAGIC: if (magic_ok && pos_ge7) phase_next = ochp_pkg::PH_VLEN;
        ochp_pkg::PH_VLEN: begin
          if (done_word) phase_next = len_zero ? ochp_pkg::PH_COUNT : ochp_pkg::PH_VBODY;
        end
        ochp_pkg::PH_VBODY: if (body_last) phase_next = ochp_pkg::PH_COUNT;
        ochp_pkg::PH_COUNT: begin
          if (done_word) phase_next = len_zero ? ochp_pkg::PH_IGNORE : ochp_pkg::PH_CLEN;
        end
        ochp_pkg::PH_CLEN: begin
          if (done_word) begin
            if (!len_zero)         phase_next = ochp_pkg::PH_CBODY;
            else if (last_comment) phase_next = ochp_pkg::PH_DONE;
          end
        end
        ochp_pkg::PH_CBODY: begin
          if (body_last) phase_next = last_comment ? ochp_pkg::PH_DONE : ochp_pkg::PH_CLEN;
        end
        ochp_pkg::PH_DONE:   phase_next = phase;
        ochp_pkg::PH_IGNORE: phase_next = phase;
        default:             phase_next = phase;
      endcase
    end
  end

  // Event built from this byte
  always_comb begin
    ev = '0;
    if (active) begin
      unique case (phase)
        ochp_pkg::PH_VLEN: begin
          if (done_word && len_zero) begin
            ev.rec_valid  = 1'b1;
            ev.rec_kind   = ochp_pkg::KIND_VENDOR;
            ev.rec_offset = start_here;
          end
        end
        ochp_pkg::PH_VBODY: begin
          if (body_last) begin
            ev.rec_valid  = 1'b1;
            ev.rec_kind   = ochp_pkg::KIND_VENDOR;
            ev.rec_offset = start_here;
            ev.rec_length = length_accumulator;
          end
        end
        ochp_pkg::PH_CLEN: begin
          if (done_word && len_zero) begin
            ev.rec_valid  = 1'b1;
            ev.rec_kind   = ochp_pkg::KIND_COMMENT;
            ev.rec_index  = current_comment_index;
            ev.rec_offset = start_here;
          end
        end
        ochp_pkg::PH_CBODY: begin
          if (body_last) begin
            ev.rec_valid  = 1'b1;
            ev.rec_kind   = ochp_pkg::KIND_COMMENT;
            ev.rec_index  = current_comment_index;
            ev.rec_offset = start_here;
            ev.rec_length = length_accumulator;
          end
        end
        default: ev.rec_valid = 1'b0;
      endcase
    end
    // Status on the last byte of the packet
    if (accept && final_byte) begin
      ev.stat_valid = 1'b1;
      priority if (pos_short)                   ev.status = ochp_pkg::ST_SHORT;
      else if (bad_next)                        ev.status = ochp_pkg::ST_BAD_MAGIC;
      else if (phase == ochp_pkg::PH_DONE)      ev.status = ochp_pkg::ST_TRAILING;
      else if (phase == ochp_pkg::PH_IGNORE)    ev.status = ochp_pkg::ST_OK;
      else if (phase_next == ochp_pkg::PH_DONE || phase_next == ochp_pkg::PH_IGNORE)
                                                ev.status = ochp_pkg::ST_OK;
      else                                      ev.status = ochp_pkg::ST_TRUNCATED;
    end
  end

  assign ev_push = ev.rec_valid || ev.stat_valid;

  // State registers; the last byte of a packet returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      phase                 <= ochp_pkg::PH_MAGIC;
      pos                   <= '0;
      field_byte_count      <= 2'd0;
      length_accumulator    <= 32'd0;
      body_bytes_left       <= '0;
      comments_left         <= '0;
      current_comment_index <= 32'd0;
      bad_magic             <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      bad_magic <= bad_next;
      if (pos != ochp_pkg::POS_MAX) pos <= pos + ochp_pkg::POS_W'(1);

      if (active && phase == ochp_pkg::PH_MAGIC) field_byte_count <= 2'd0;
      else if (gathering)                        field_byte_count <= field_byte_count + 2'd1;

      if (gathering) length_accumulator <= done_word ? 32'(len_word) : acc_shifted;

      // Body countdown
      if (done_word && !len_zero &&
          (phase == ochp_pkg::PH_VLEN || phase == ochp_pkg::PH_CLEN)) begin
        body_bytes_left <= len_word;
      end else if (active && (phase == ochp_pkg::PH_VBODY || phase == ochp_pkg::PH_CBODY)) begin
        body_bytes_left <= body_bytes_left - LENGTH_BITS'(1);
      end

      // Comment bookkeeping
      if (done_word && phase == ochp_pkg::PH_COUNT) begin
        comments_left         <= len_word;
        current_comment_index <= 32'd0;
      end else if (ev.rec_valid && ev.rec_kind == ochp_pkg::KIND_COMMENT) begin
        comments_left         <= comments_left - LENGTH_BITS'(1);
        current_comment_index <= current_comment_index + 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ochp_queue.sv
// Short event queue between the parser and the result stage.
// Depends on ochp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ochp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ochp_pkg::ev_t push_ev,
  output logic               full,
  input  wire logic          take,
  output ochp_pkg::ev_t      head,
  output logic               nonempty
);

  localparam int PTR_W = (ochp_pkg::QDEPTH > 1) ? $clog2(ochp_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(ochp_pkg::QDEPTH + 1);

  ochp_pkg::ev_t    entries [ochp_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_take;

  assign full     = count == CNT_W'(ochp_pkg::QDEPTH);
  assign nonempty = count != '0;
  assign head     = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_take  = take && nonempty;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_ev;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(ochp_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_take) rd_ptr <= (rd_ptr == PTR_W'(ochp_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_take)      count <= count + CNT_W'(1);
      else if (do_take && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ochp_emit.sv
// Result stage: expands each event into one or two result items.
// Depends on ochp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ochp_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ochp_pkg::ev_t head,
  input  wire logic          head_valid,
  output logic               take,
  output logic               empty,
  input  wire logic          pop,
  output logic [1:0]         record_kind,
  output logic [31:0]        comment_index,
  output logic [31:0]        field_offset,
  output logic [31:0]        field_length,
  output logic [2:0]         parse_status,
  output logic               run_end
);

  ochp_pkg::ev_t cur;
  logic          cur_valid;
  logic          rec_sent;
  logic          show_stat;
  logic          last_item;
  logic          done;

  // Status shows once the record (if any) has gone
  assign show_stat = !cur.rec_valid || rec_sent;
  assign last_item = show_stat || !cur.stat_valid;
  assign done      = cur_valid && pop && last_item;
  assign take      = head_valid && (!cur_valid || done);
  assign empty     = !cur_valid;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rec_sent  <= 1'b0;
    end else if (take) begin
      cur_valid <= 1'b1;
      rec_sent  <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      rec_sent  <= 1'b0;
    end else if (cur_valid && pop) begin
      rec_sent  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= head;
  end

  // Result fields
  assign record_kind   = show_stat ? ochp_pkg::KIND_STATUS : cur.rec_kind;
  assign comment_index = show_stat ? 32'd0 : cur.rec_index;
  assign field_offset  = show_stat ? 32'd0 : cur.rec_offset;
  assign field_length  = show_stat ? 32'd0 : cur.rec_length;
  assign parse_status  = show_stat ? cur.status : ochp_pkg::ST_OK;
  assign run_end       = last_item;

endmodule

`default_nettype wire

FILE: hdl/opus_comment_header_parser.sv
// Top level of the comment header parser.
// Depends on ochp_pkg, ochp_front, ochp_queue and ochp_emit.
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for a comment header packet, one byte per item. Bytes
// are taken at one per clock while full is low; the parser keeps no
// pipeline of its own, so every byte is decoded in the cycle it is taken
// and its records land in a four-entry event queue. A byte causes at most
// two result items (a string record and the final status); the result side
// hands out one item per cycle while pop is high, so a byte that closes a
// string on the last byte of a packet needs two pops, and full rises only
// when the queue has filled behind a stalled or slower consumer. The state
// returns to reset after each final byte, so packets may follow back to back.
module opus_comment_header_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       record_kind,
  output logic [31:0]      comment_index,
  output logic [31:0]      field_offset,
  output logic [31:0]      field_length,
  output logic [2:0]       parse_status,
  output logic             run_end
);

  logic          accept;
  logic          ev_push;
  ochp_pkg::ev_t ev;
  ochp_pkg::ev_t head;
  logic          head_valid;
  logic          take;

  assign accept = push && !full;

  // Byte parser
  ochp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .final_byte(final_byte),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  // Event queue
  ochp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (ev_push),
    .push_ev (ev),
    .full    (full),
    .take    (take),
    .head    (head),
    .nonempty(head_valid)
  );

  // Result stage
  ochp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .record_kind  (record_kind),
    .comment_index(comment_index),
    .field_offset (field_offset),
    .field_length (field_length),
    .parse_status (parse_status),
    .run_end      (run_end)
  );

endmodule

`default_nettype wire
